>>> rtl/ufg_pkg.sv
// Package for the UV sphere face generator.
// Widths, face kinds and fixed-point constants; used by every rtl file.
package ufg_pkg;

	localparam int MAX_SLICES = 256;
	localparam int MAX_STACKS = 256;
	localparam int CFG_W      = 9;
	localparam int BAND_W     = 8;
	localparam int SLICE_W    = 9;
	localparam int VERT_W     = 16;
	localparam int TEX_W      = 17;
	localparam int RECIP_W    = 24;
	localparam int VSUM_W     = 18;

	localparam logic [CFG_W-1:0] SLICE_MIN   = 9'd3;
	localparam logic [CFG_W-1:0] STACK_MIN   = 9'd2;
	localparam logic [CFG_W-1:0] SLICE_MAX   = CFG_W'(MAX_SLICES);
	localparam logic [CFG_W-1:0] STACK_MAX   = CFG_W'(MAX_STACKS);
	localparam logic [CFG_W-1:0] SLICE_RESET = 9'd16;
	localparam logic [CFG_W-1:0] STACK_RESET = 9'd16;
	localparam logic [TEX_W-1:0] FIX_ONE     = 17'h10000;

	typedef enum logic {
		REG_SLICE_COUNT = 1'b0,
		REG_STACK_COUNT = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		FACE_NORTH = 2'd0,
		FACE_SOUTH = 2'd1,
		FACE_MID   = 2'd2
	} face_kind_t;

endpackage

>>> rtl/ufg_recip.sv
// Bit-serial reciprocal unit: recip = floor(2^24 / d), one quotient bit per cycle.
// Depends on ufg_pkg.
module ufg_recip (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [ufg_pkg::CFG_W-1:0]    d,
	output logic [ufg_pkg::RECIP_W-1:0]  recip,
	output logic                         busy
);

	logic                         busy_q;
	logic [4:0]                   cnt_q;
	logic [ufg_pkg::CFG_W-1:0]    d_q;
	logic [ufg_pkg::CFG_W-1:0]    rem_q;
	logic [ufg_pkg::RECIP_W-1:0]  quo_q;
	logic [ufg_pkg::CFG_W:0]      trial;
	logic                         fits;

	assign trial = {rem_q, (cnt_q == 5'd0)};
	assign fits  = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'(ufg_pkg::RECIP_W))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			d_q   <= d;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? ufg_pkg::CFG_W'(trial - {1'b0, d_q}) : trial[ufg_pkg::CFG_W-1:0];
			quo_q <= {quo_q[ufg_pkg::RECIP_W-2:0], fits};
		end
	end

	assign recip = quo_q;
	assign busy  = busy_q;

endmodule

>>> rtl/ufg_qdiv.sv
// Pipelined divider lane: (num << 16) / den via reciprocal multiply and one correction.
// Depends on ufg_pkg; num/den pass through the s2 and s3 registers while en is high, and quo is formed from s3.
module ufg_qdiv (
	input  logic                         clk,
	input  logic                         en,
	input  logic [ufg_pkg::SLICE_W-1:0]  num,
	input  logic [ufg_pkg::CFG_W-1:0]    den,
	input  logic [ufg_pkg::RECIP_W-1:0]  recip,
	output logic [ufg_pkg::TEX_W-1:0]    quo
);

	logic [32:0]                  prod;
	logic [ufg_pkg::TEX_W-1:0]    qe_s2, qe_s3;
	logic [ufg_pkg::SLICE_W-1:0]  num_s2;
	logic [ufg_pkg::CFG_W-1:0]    den_s2, den_s3;
	logic [25:0]                  chk_s3;
	logic [24:0]                  x_s3;
	logic [24:0]                  rem;

	assign prod = 33'(num) * 33'(recip);

	always_ff @(posedge clk) begin
		if (en) begin
			qe_s2  <= prod[24:8];
			num_s2 <= num;
			den_s2 <= den;
			qe_s3  <= qe_s2;
			den_s3 <= den_s2;
			chk_s3 <= 26'(qe_s2) * 26'(den_s2);
			x_s3   <= {num_s2, 16'b0};
		end
	end

	assign rem = x_s3 - chk_s3[24:0];
	assign quo = qe_s3 + ufg_pkg::TEX_W'(rem >= {16'b0, den_s3});

endmodule

>>> rtl/uv_sphere_face_generator.sv
// UV sphere face generator top level: four-stage face pipeline and reciprocal units.
// Depends on ufg_pkg, ufg_recip, ufg_qdiv.
//
//  channel   direction  handshake              payload
//  in        into       in_valid / in_stall    band_index, slice_number, lower_half
//  out       out of     out_valid / out_stall  vertex_a..c, tex_u/v_a..c, bad_request
//  cfg       into       cfg_we                 cfg_index, cfg_data
//
// One face per cycle while in_stall is low; four register stages, out_valid is registered from stage 3's valid.
// Stages: input reg, reciprocal multiply, check multiply and vertex sums, correct and output.
// After reset and after every register write, in_stall holds while the reciprocals of
// the slice count, the slice count minus one and the stack count are rebuilt one bit per cycle.
// out_stall freezes the whole pipeline while out_valid is high; nothing is dropped or repeated.
module uv_sphere_face_generator (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [ufg_pkg::CFG_W-1:0]    cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [ufg_pkg::BAND_W-1:0]   band_index,
	input  logic [ufg_pkg::SLICE_W-1:0]  slice_number,
	input  logic                         lower_half,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [ufg_pkg::VERT_W-1:0]   vertex_a,
	output logic [ufg_pkg::VERT_W-1:0]   vertex_b,
	output logic [ufg_pkg::VERT_W-1:0]   vertex_c,
	output logic [ufg_pkg::TEX_W-1:0]    tex_u_a,
	output logic [ufg_pkg::TEX_W-1:0]    tex_v_a,
	output logic [ufg_pkg::TEX_W-1:0]    tex_u_b,
	output logic [ufg_pkg::TEX_W-1:0]    tex_v_b,
	output logic [ufg_pkg::TEX_W-1:0]    tex_u_c,
	output logic [ufg_pkg::TEX_W-1:0]    tex_v_c,
	output logic                         bad_request
);

	localparam int CW = ufg_pkg::CFG_W;
	localparam int VW = ufg_pkg::VSUM_W;
	localparam int TW = ufg_pkg::TEX_W;

	logic [CW-1:0] slice_q, stack_q;
	logic [CW-1:0] ns, nt, ns_m1;
	logic          start_q;
	logic [ufg_pkg::RECIP_W-1:0] rcp_s, rcp_s1m, rcp_t;
	logic          busy_s, busy_s1m, busy_t, busy;
	logic          en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slice_q <= ufg_pkg::SLICE_RESET;
			stack_q <= ufg_pkg::STACK_RESET;
			start_q <= 1'b1;
		end else begin
			start_q <= cfg_we;
			if (cfg_we) begin
				unique case (ufg_pkg::cfg_reg_t'(cfg_index))
					ufg_pkg::REG_SLICE_COUNT: slice_q <= cfg_data;
					ufg_pkg::REG_STACK_COUNT: stack_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		ns = slice_q;
		if (slice_q < ufg_pkg::SLICE_MIN) ns = ufg_pkg::SLICE_MIN;
		else if (slice_q > ufg_pkg::SLICE_MAX) ns = ufg_pkg::SLICE_MAX;
		nt = stack_q;
		if (stack_q < ufg_pkg::STACK_MIN) nt = ufg_pkg::STACK_MIN;
		else if (stack_q > ufg_pkg::STACK_MAX) nt = ufg_pkg::STACK_MAX;
		ns_m1 = ns - CW'(1);
	end

	ufg_recip u_rcp_s   (.clk, .arst_n, .start(start_q), .d(ns),    .recip(rcp_s),   .busy(busy_s));
	ufg_recip u_rcp_s1m (.clk, .arst_n, .start(start_q), .d(ns_m1), .recip(rcp_s1m), .busy(busy_s1m));
	ufg_recip u_rcp_t   (.clk, .arst_n, .start(start_q), .d(nt),    .recip(rcp_t),   .busy(busy_t));

	assign busy     = start_q | busy_s | busy_s1m | busy_t;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en || busy;

	// stage 1: input word
	logic                        valid_s1, half_s1;
	logic [ufg_pkg::BAND_W-1:0]  band_s1;
	logic [ufg_pkg::SLICE_W-1:0] i_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (en)
			valid_s1 <= in_valid && !busy;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			band_s1 <= band_index;
			i_s1    <= slice_number;
			half_s1 <= lower_half;
		end
	end

	logic             bad1;
	ufg_pkg::face_kind_t kind1;
	logic [8:0]       band1_9;

	assign band1_9 = {1'b0, band_s1};
	assign bad1 = (band1_9 >= nt) || (i_s1 == '0) || (i_s1 > ns);

	always_comb begin
		if (band_s1 == '0)                kind1 = ufg_pkg::FACE_NORTH;
		else if (band1_9 == nt - CW'(1))  kind1 = ufg_pkg::FACE_SOUTH;
		else                              kind1 = ufg_pkg::FACE_MID;
	end

	// divider lanes: l0 (i-1)/S, l1 i/S, l2 (i-1)/(S-1), l3 b/T, l4 (b+1)/T
	logic [TW-1:0] l0, l1, l2, l3, l4;

	ufg_qdiv u_l0 (.clk, .en, .num(i_s1 - 9'd1), .den(ns),    .recip(rcp_s),   .quo(l0));
	ufg_qdiv u_l1 (.clk, .en, .num(i_s1),        .den(ns),    .recip(rcp_s),   .quo(l1));
	ufg_qdiv u_l2 (.clk, .en, .num(i_s1 - 9'd1), .den(ns_m1), .recip(rcp_s1m), .quo(l2));
	ufg_qdiv u_l3 (.clk, .en, .num(band1_9),     .den(nt),    .recip(rcp_t),   .quo(l3));
	ufg_qdiv u_l4 (.clk, .en, .num(band1_9 + 9'd1), .den(nt), .recip(rcp_t),   .quo(l4));

	// stage 2: ring base and pole sums
	logic                        valid_s2, half_s2, bad_s2;
	ufg_pkg::face_kind_t         kind_s2;
	logic [ufg_pkg::SLICE_W-1:0] i_s2;
	logic [CW-1:0]               ns_s2;
	logic [VW-1:0]               base_s2, nsum_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (en)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			half_s2 <= half_s1;
			bad_s2  <= bad1;
			kind_s2 <= kind1;
			i_s2    <= i_s1;
			ns_s2   <= ns;
			base_s2 <= VW'(VW'(band1_9 - 9'd1) * VW'(ns));
			nsum_s2 <= VW'(VW'(nt - CW'(1)) * VW'(ns));
		end
	end

	// stage 3: vertex indices
	logic                        valid_s3, half_s3, bad_s3;
	ufg_pkg::face_kind_t         kind_s3;
	logic [ufg_pkg::VERT_W-1:0]  va_s3, vb_s3, vc_s3;
	logic [VW-1:0]               va2, vb2, vc2, vi, vs, pp, qq, rr, ss;
	logic                        wrap2;

	always_comb begin
		vi    = VW'(i_s2);
		vs    = VW'(ns_s2);
		wrap2 = (i_s2 == ns_s2);
		pp    = base_s2 + vi;
		qq    = pp + vs;
		rr    = wrap2 ? base_s2 + vs + VW'(1) : qq + VW'(1);
		ss    = wrap2 ? base_s2 + VW'(1) : pp + VW'(1);
		unique case (kind_s2)
			ufg_pkg::FACE_NORTH: begin
				va2 = '0;
				vb2 = vi;
				vc2 = wrap2 ? VW'(1) : vi + VW'(1);
			end
			ufg_pkg::FACE_SOUTH: begin
				va2 = nsum_s2 + VW'(1);
				vb2 = wrap2 ? nsum_s2 + VW'(1) - vs : nsum_s2 + VW'(1) - vs + vi;
				vc2 = nsum_s2 - vs + vi;
			end
			default: begin
				va2 = pp;
				vb2 = half_s2 ? rr : qq;
				vc2 = half_s2 ? ss : rr;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s3 <= 1'b0;
		else if (en)
			valid_s3 <= valid_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			half_s3 <= half_s2;
			bad_s3  <= bad_s2;
			kind_s3 <= kind_s2;
			va_s3   <= va2[ufg_pkg::VERT_W-1:0];
			vb_s3   <= vb2[ufg_pkg::VERT_W-1:0];
			vc_s3   <= vc2[ufg_pkg::VERT_W-1:0];
		end
	end

	// stage 4: texture select and output word
	logic [TW-1:0] ua, wa, ub, wb, uc, wc;

	always_comb begin
		unique case (kind_s3)
			ufg_pkg::FACE_NORTH: begin
				ua = l2; wa = '0; ub = l0; wb = l4; uc = l1; wc = l4;
			end
			ufg_pkg::FACE_SOUTH: begin
				ua = l2; wa = ufg_pkg::FIX_ONE; ub = l1; wb = l3; uc = l0; wc = l3;
			end
			default: begin
				ua = l0; wa = l3; wb = l4; uc = l1;
				ub = half_s3 ? l1 : l0;
				wc = half_s3 ? l3 : l4;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (en)
			out_valid <= valid_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bad_request <= bad_s3;
			vertex_a    <= bad_s3 ? '0 : va_s3;
			vertex_b    <= bad_s3 ? '0 : vb_s3;
			vertex_c    <= bad_s3 ? '0 : vc_s3;
			tex_u_a     <= bad_s3 ? '0 : ua;
			tex_v_a     <= bad_s3 ? '0 : wa;
			tex_u_b     <= bad_s3 ? '0 : ub;
			tex_v_b     <= bad_s3 ? '0 : wb;
			tex_u_c     <= bad_s3 ? '0 : uc;
			tex_v_c     <= bad_s3 ? '0 : wc;
		end
	end

endmodule

>>> rtl/ufg_checker.sv
// Port-level checker for the UV sphere face generator, bound to the top level.
// Depends on ufg_pkg and uv_sphere_face_generator.
module ufg_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         cfg_we,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [ufg_pkg::VERT_W-1:0]   vertex_a,
	input logic [ufg_pkg::VERT_W-1:0]   vertex_b,
	input logic [ufg_pkg::VERT_W-1:0]   vertex_c,
	input logic [ufg_pkg::TEX_W-1:0]    tex_u_a,
	input logic [ufg_pkg::TEX_W-1:0]    tex_v_a,
	input logic [ufg_pkg::TEX_W-1:0]    tex_u_c,
	input logic                         bad_request
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(vertex_a) && $stable(tex_u_a))
		else $error("stalled output word changed");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_request |-> vertex_a == '0 && vertex_b == '0 && vertex_c == '0
			&& tex_u_a == '0 && tex_v_a == '0 && tex_u_c == '0)
		else $error("bad request word carries nonzero fields");

	a_tex_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> tex_u_a <= ufg_pkg::FIX_ONE && tex_v_a <= ufg_pkg::FIX_ONE
			&& tex_u_c <= ufg_pkg::FIX_ONE)
		else $error("texture coordinate above 1.0");

	a_cfg_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> in_stall)
		else $error("input taken while reciprocals rebuild");

endmodule

bind uv_sphere_face_generator ufg_checker u_ufg_checker (.*);
